// File: rtl/gwp_pkg.sv
// Shared types and constants for the grid wave path router.
// No dependencies.
package gwp_pkg;
  localparam int unsigned MAX_ROWS = 32;
  localparam int unsigned MAX_COLS = 32;
  localparam int unsigned DistW = 11;
  localparam logic [DistW-1:0] DistNone = '1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;
  localparam logic IDX_ROWS   = 1'b0;
  localparam logic IDX_COLS   = 1'b1;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_CLEAR = 8'b00000010,
    ST_SCAN  = 8'b00000100,
    ST_EVAL  = 8'b00001000,
    ST_NRD   = 8'b00010000,
    ST_NCHK  = 8'b00100000,
    ST_BRD   = 8'b01000000,
    ST_BCHK  = 8'b10000000
  } state_t;
endpackage

// File: rtl/gwp_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module gwp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/grid_wave_path_next_step.sv
// Lee wave maze router: a write item stores one cell; a search item labels distances
// wave by wave with frame sweeps over one distance RAM, then backtraces from the goal.
// A write stores its cell as it is accepted; a search first clears the distance RAM, then runs
// one wave sweep per path step, reading each cell and its neighbours, then backtraces step by step.
// Throughput: one item at a time; input stalls until the result transfers.
// Reset: sync; the open map is cleared to walls before input is taken.
module grid_wave_path_next_step
  import gwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [4:0] in_row,
  input  logic [4:0] in_col,
  input  logic       in_cell_open,
  input  logic [4:0] in_goal_row,
  input  logic [4:0] in_goal_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_found,
  output logic [4:0] out_next_row,
  output logic [4:0] out_next_col,
  output logic [9:0] out_path_length,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam logic [AW:0] LastCell = (AW+1)'(CELLS - 1);

  logic [5:0] rows_r, cols_r;
  state_t state_r;
  logic clr_map_r;
  logic [AW:0] sweep_r;
  logic [4:0] sr_r, sc_r, gr_r, gc_r, cr_r, cc_r;
  logic [1:0] k_r;
  logic [DistW-1:0] wave_r, d_r;
  logic changed_r, ok_r;
  logic found_r;
  logic [4:0] nr_r, nc_r;
  logic [9:0] len_r;
  logic ov_r;

  logic [5:0] nrow, ncol;
  always_comb begin
    nrow = rows_r;
    ncol = cols_r;
    if (rows_r == 6'd0) nrow = 6'd1;
    else if (rows_r > 6'(MAX_ROWS)) nrow = 6'(MAX_ROWS);
    if (cols_r == 6'd0) ncol = 6'd1;
    else if (cols_r > 6'(MAX_COLS)) ncol = 6'(MAX_COLS);
  end

  function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [4:0] c);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  logic map_we, map_wd, map_rd;
  logic [AW-1:0] map_wa, map_ra;
  gwp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_rd)
  );
  logic dist_we;
  logic [DistW-1:0] dist_wd, dist_rd;
  logic [AW-1:0] dist_wa, dist_ra;
  gwp_ram #(.WIDTH(DistW), .DEPTH(CELLS)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra), .rdata(dist_rd)
  );

  logic [5:0] nbr, nbc;
  logic nb_in;
  always_comb begin
    nbr = {1'b0, cr_r};
    nbc = {1'b0, cc_r};
    case (k_r)
      DIR_DOWN:  nbr = {1'b0, cr_r} + 6'd1;
      DIR_RIGHT: nbc = {1'b0, cc_r} + 6'd1;
      DIR_UP:    nbr = {1'b0, cr_r} - 6'd1;
      default:   nbc = {1'b0, cc_r} - 6'd1;
    endcase
    nb_in = (nbr < nrow) && (nbc < ncol);
  end

  logic [AW-1:0] start_addr, goal_addr, cell_addr, nb_addr;
  assign start_addr = addr_of(sr_r, sc_r);
  assign goal_addr  = addr_of(gr_r, gc_r);
  assign cell_addr  = addr_of(cr_r, cc_r);
  assign nb_addr    = addr_of(nbr[4:0], nbc[4:0]);

  assign in_stall = (state_r != ST_IDLE) || clr_map_r || ov_r;
  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  logic nb_hit, goal_hit, changed_now, cell_done;
  logic bt_match, bt_adv;
  logic [4:0] pr, pc;
  always_comb begin
    nb_hit = map_rd && (dist_rd == DistNone);
    goal_hit = nb_hit && (nbr[4:0] == gr_r) && (nbc[4:0] == gc_r);
    changed_now = changed_r || ((state_r == ST_NCHK) && nb_hit);
    cell_done = 1'b0;
    case (state_r)
      ST_EVAL: cell_done = (dist_rd != wave_r - 1'b1);
      ST_NRD:  cell_done = !nb_in && (k_r == DIR_LEFT);
      ST_NCHK: cell_done = !goal_hit && (k_r == DIR_LEFT);
      default: ;
    endcase
    bt_match = (state_r == ST_BCHK) && (dist_rd == d_r - 1'b1);
    bt_adv = bt_match || ((k_r == DIR_LEFT) &&
             ((state_r == ST_BCHK) || ((state_r == ST_BRD) && !nb_in)));
    pr = bt_match ? nbr[4:0] : cr_r;
    pc = bt_match ? nbc[4:0] : cc_r;
  end

  always_comb begin
    map_we = 1'b0;
    map_wa = addr_of(in_row, in_col);
    map_wd = in_cell_open;
    if (clr_map_r) begin
      map_we = 1'b1; map_wa = sweep_r[AW-1:0]; map_wd = 1'b0;
    end else if (in_xfer && in_req_type == REQ_WRITE) begin
      map_we = 1'b1;
    end
    map_ra = nb_addr;
    dist_ra = nb_addr;
    dist_we = 1'b0; dist_wa = nb_addr; dist_wd = wave_r;
    case (state_r)
      ST_CLEAR: begin
        map_ra = (sweep_r == '0) ? start_addr : goal_addr;
        dist_we = 1'b1;
        dist_wa = sweep_r[AW-1:0];
        dist_wd = (sweep_r[AW-1:0] == start_addr) ? '0 : DistNone;
      end
      ST_SCAN: dist_ra = cell_addr;
      ST_NCHK: dist_we = nb_hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 6'd32; cols_r <= 6'd32;
      state_r <= ST_IDLE; clr_map_r <= 1'b1;
      sweep_r <= '0; ov_r <= 1'b0;
      found_r <= 1'b0; nr_r <= '0; nc_r <= '0; len_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          IDX_ROWS: rows_r <= cfg_data;
          IDX_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (clr_map_r) begin
        if (sweep_r == LastCell) begin
          clr_map_r <= 1'b0; sweep_r <= '0;
        end else begin
          sweep_r <= sweep_r + 1'b1;
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            nr_r <= '0; nc_r <= '0; len_r <= '0;
            if (in_req_type == REQ_WRITE) begin
              found_r <= 1'b1; ov_r <= 1'b1;
            end else begin
              found_r <= 1'b0;
              sr_r <= in_row; sc_r <= in_col;
              gr_r <= in_goal_row; gc_r <= in_goal_col;
              ok_r <= ({1'b0, in_row} < nrow) && ({1'b0, in_col} < ncol) &&
                      ({1'b0, in_goal_row} < nrow) && ({1'b0, in_goal_col} < ncol);
              state_r <= ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          if (sweep_r == (AW+1)'(1) || sweep_r == (AW+1)'(2)) ok_r <= ok_r && map_rd;
          if (sweep_r == LastCell) begin
            sweep_r <= '0;
            if (!ok_r) begin
              ov_r <= 1'b1; state_r <= ST_IDLE;
            end else if (sr_r == gr_r && sc_r == gc_r) begin
              found_r <= 1'b1; nr_r <= sr_r; nc_r <= sc_r;
              ov_r <= 1'b1; state_r <= ST_IDLE;
            end else begin
              wave_r <= DistW'(1); cr_r <= '0; cc_r <= '0;
              changed_r <= 1'b0; state_r <= ST_SCAN;
            end
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        ST_SCAN: state_r <= ST_EVAL;
        ST_EVAL: begin
          if (!cell_done) begin
            k_r <= DIR_DOWN; state_r <= ST_NRD;
          end
        end
        ST_NRD: begin
          if (!cell_done) begin
            if (nb_in) state_r <= ST_NCHK;
            else k_r <= k_r + 2'd1;
          end
        end
        ST_NCHK: begin
          if (goal_hit) begin
            len_r <= (wave_r > DistW'(1023)) ? 10'd1023 : wave_r[9:0];
            if (wave_r == DistW'(1)) begin
              found_r <= 1'b1; nr_r <= gr_r; nc_r <= gc_r;
              ov_r <= 1'b1; state_r <= ST_IDLE;
            end else begin
              cr_r <= gr_r; cc_r <= gc_r; d_r <= wave_r;
              k_r <= DIR_DOWN; state_r <= ST_BRD;
            end
          end else if (!cell_done) begin
            if (nb_hit) changed_r <= 1'b1;
            k_r <= k_r + 2'd1; state_r <= ST_NRD;
          end
        end
        ST_BRD: begin
          if (!bt_adv) begin
            if (nb_in) state_r <= ST_BCHK;
            else k_r <= k_r + 2'd1;
          end
        end
        ST_BCHK: begin
          if (!bt_adv) begin
            k_r <= k_r + 2'd1; state_r <= ST_BRD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cell_done) begin
        k_r <= DIR_DOWN;
        if ({1'b0, cc_r} + 6'd1 < ncol) begin
          cc_r <= cc_r + 5'd1; changed_r <= changed_now; state_r <= ST_SCAN;
        end else if ({1'b0, cr_r} + 6'd1 < nrow) begin
          cc_r <= '0; cr_r <= cr_r + 5'd1; changed_r <= changed_now; state_r <= ST_SCAN;
        end else if (changed_now) begin
          cr_r <= '0; cc_r <= '0; changed_r <= 1'b0;
          wave_r <= wave_r + 1'b1; state_r <= ST_SCAN;
        end else begin
          ov_r <= 1'b1; state_r <= ST_IDLE;
        end
      end
      if (bt_adv) begin
        k_r <= DIR_DOWN;
        if (d_r == DistW'(2)) begin
          found_r <= 1'b1; nr_r <= pr; nc_r <= pc;
          ov_r <= 1'b1; state_r <= ST_IDLE;
        end else begin
          cr_r <= pr; cc_r <= pc; d_r <= d_r - 1'b1; state_r <= ST_BRD;
        end
      end
    end
  end

  assign out_valid = ov_r;
  assign out_found = found_r;
  assign out_next_row = nr_r;
  assign out_next_col = nc_r;
  assign out_path_length = len_r;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable({found_r, nr_r, nc_r, len_r})))
    else $error("result changed while stalled");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_map_r |-> (state_r == ST_IDLE)) else $error("search during map clear");
`endif
endmodule
